>>> rtl/core/swe_pkg.sv
package swe_pkg;

   // default build sizes
   localparam int WINDOW_MAX_DEFAULT  = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // configuration register map
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_SIZE = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE        = 1'b1;

   // reset value of the window size configuration register
   localparam logic [CSR_DATA_BITS-1:0] WINDOW_SIZE_RESET = 7'd1;

   // command broadcast to every cell of the deque row
   typedef struct packed {
      logic clear;     // restart: the row is empty before this sample goes in
      logic pop;       // front entry has left the window, row shifts toward cell 0
      logic append;    // sample is taken in this cycle
      logic min_mode;  // 1 tracks minimum, 0 tracks maximum
   } cell_cmd_type;

endpackage

>>> rtl/core/swe_cell.sv
module swe_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int POS_BITS    = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swe_pkg::cell_cmd_type  cmd,
   input  logic [SAMPLE_BITS-1:0] new_value,
   input  logic [POS_BITS-1:0]    new_pos,
   // neighbor toward the back of the deque
   input  logic                   up_valid,
   input  logic [SAMPLE_BITS-1:0] up_value,
   input  logic [POS_BITS-1:0]    up_pos,
   // neighbor toward the front keeps its entry
   input  logic                   prev_keep,
   output logic                   keep,
   // stored entry
   output logic                   valid,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [POS_BITS-1:0]    pos
);
   import swe_pkg::*;

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] value_ff, value_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;

   logic                   src_valid;
   logic [SAMPLE_BITS-1:0] src_value;
   logic [POS_BITS-1:0]    src_pos;
   logic                   dominated;

   // entry seen by this cell after an optional shift from the back neighbor
   always_comb begin
      src_valid = cmd.pop ? up_valid : valid_ff;
      src_value = cmd.pop ? up_value : value_ff;
      src_pos   = cmd.pop ? up_pos   : pos_ff;
      if (cmd.clear) begin
         src_valid = 1'b0;
      end
   end

   // the new sample makes this entry useless: newer equal values win
   always_comb begin
      if (cmd.min_mode) begin
         dominated = $signed(src_value) >= $signed(new_value);
      end else begin
         dominated = $signed(src_value) <= $signed(new_value);
      end
   end

   assign keep = src_valid && !(cmd.append && dominated);

   // first free slot behind the surviving entries takes the sample
   always_comb begin
      valid_in = keep;
      value_in = src_value;
      pos_in   = src_pos;
      if (cmd.append && prev_keep && !keep) begin
         valid_in = 1'b1;
         value_in = new_value;
         pos_in   = new_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      pos_ff   <= pos_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign pos   = pos_ff;

endmodule

>>> rtl/core/sliding_window_extreme.sv
// Running maximum (mode 0) or minimum (mode 1) over the last window_size
// samples, window_size from 1 to WINDOW_MAX (0 acts as 1, larger values as
// WINDOW_MAX). The deque lives in a row of WINDOW_MAX cells, front in cell 0;
// each cell compares its entry with the incoming sample in parallel, so one
// sample completes per clock. A sample whose arrival expires more than one
// front entry at once (only after window_size was lowered) waits while the
// further expired entries are popped one at a time, since expiry is checked
// on cells 0 and 1 only. A sample is held in an input register and the result
// in an output register, so a sample can be taken while the previous result
// waits; a sample is worked from the input register once the output register
// is free, and its result is valid from the edge that appends it to the row.
// A waiting result holds the row, and so the next sample, until its transfer.
// tuser on the request marks a restart: the deque, the fill count and the
// position are cleared before that sample. A result is given once window_size
// samples have arrived since the last restart. Write configuration only while idle.
module sliding_window_extreme #(
   parameter int WINDOW_MAX  = swe_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // request channel
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        req_tdata,   // sample
   input  logic                                    req_tuser,   // restart
   // result channel
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,   // extreme
   // configuration writes
   input  logic                                    csr_we,
   input  logic [swe_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [swe_pkg::CSR_DATA_BITS-1:0]       csr_wdata
);
   import swe_pkg::*;

   localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int POS_MOD   = 2 * WINDOW_MAX;
   localparam int POS_BITS  = $clog2(POS_MOD);
   localparam int WIN_BITS  = $clog2(WINDOW_MAX + 1);

   // configuration
   logic [CSR_DATA_BITS-1:0] window_size_ff, window_size_in;
   logic                     mode_ff, mode_in;

   // held sample
   logic                   hold_valid_ff, hold_valid_in;
   logic [SAMPLE_BITS-1:0] hold_sample_ff, hold_sample_in;
   logic                   hold_restart_ff, hold_restart_in;

   // sequence state
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [WIN_BITS-1:0] fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // cell row
   logic                   cell_valid [WINDOW_MAX:0];
   logic [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX:0];
   logic [POS_BITS-1:0]    cell_pos   [WINDOW_MAX:0];
   logic                   cell_keep  [WINDOW_MAX:0];
   cell_cmd_type           cmd;

   logic [WIN_BITS-1:0] win_eff;
   logic [POS_BITS-1:0] item_pos;
   logic [POS_BITS-1:0] age0, age1;
   logic                exp0, exp1;
   logic                out_free, step, pop_only, finish;
   logic [WIN_BITS-1:0] fill_nxt;
   logic                emit;

   // distance from an entry's position to the current one, modulo POS_MOD
   function automatic logic [POS_BITS-1:0] age_of(input logic [POS_BITS-1:0] now,
                                                  input logic [POS_BITS-1:0] then_pos);
      logic [POS_BITS:0] sum;
      begin
         if (now >= then_pos) begin
            sum = {1'b0, now} - {1'b0, then_pos};
         end else begin
            sum = {1'b0, now} + (POS_BITS+1)'(POS_MOD) - {1'b0, then_pos};
         end
         return sum[POS_BITS-1:0];
      end
   endfunction

   // configuration writes
   always_comb begin
      window_size_in = window_size_ff;
      mode_in        = mode_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW_SIZE: window_size_in = csr_wdata;
            CSR_MODE:        mode_in        = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // effective window length
   always_comb begin
      if (window_size_ff == '0) begin
         win_eff = WIN_BITS'(1);
      end else if (32'(window_size_ff) > WINDOW_MAX) begin
         win_eff = WIN_BITS'(WINDOW_MAX);
      end else begin
         win_eff = WIN_BITS'(window_size_ff);
      end
   end

   // front expiry on the first two cells
   assign item_pos = hold_restart_ff ? '0 : pos_ff;
   assign age0     = age_of(item_pos, cell_pos[0]);
   assign age1     = age_of(item_pos, cell_pos[1]);
   assign exp0     = cell_valid[0] && (32'(age0) >= 32'(win_eff));
   assign exp1     = cell_valid[1] && (32'(age1) >= 32'(win_eff));

   // sequencing: the row moves only when the result slot is free
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign step     = hold_valid_ff && out_free;
   assign pop_only = step && !hold_restart_ff && exp0 && exp1;
   assign finish   = step && !pop_only;

   always_comb begin
      cmd.clear    = finish && hold_restart_ff;
      cmd.pop      = step && !hold_restart_ff && exp0;
      cmd.append   = finish;
      cmd.min_mode = mode_ff;
   end

   assign req_tready = !hold_valid_ff || finish;

   // input holding register
   always_comb begin
      hold_valid_in   = hold_valid_ff && !finish;
      hold_sample_in  = hold_sample_ff;
      hold_restart_in = hold_restart_ff;
      if (req_tvalid && req_tready) begin
         hold_valid_in   = 1'b1;
         hold_sample_in  = req_tdata[SAMPLE_BITS-1:0];
         hold_restart_in = req_tuser;
      end
   end

   // fill count, position and result decision
   always_comb begin
      if (hold_restart_ff) begin
         fill_nxt = WIN_BITS'(1);
      end else if (32'(fill_ff) >= WINDOW_MAX) begin
         fill_nxt = fill_ff;
      end else begin
         fill_nxt = fill_ff + WIN_BITS'(1);
      end
      emit = 32'(fill_nxt) >= 32'(win_eff);

      fill_in      = fill_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (finish) begin
         fill_in      = fill_nxt;
         pos_in       = (32'(item_pos) == POS_MOD - 1) ? '0 : item_pos + POS_BITS'(1);
         rsp_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         mode_ff        <= 1'b0;
         hold_valid_ff  <= 1'b0;
         pos_ff         <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         mode_ff        <= mode_in;
         hold_valid_ff  <= hold_valid_in;
         pos_ff         <= pos_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      hold_sample_ff  <= hold_sample_in;
      hold_restart_ff <= hold_restart_in;
   end

   // row of deque cells, front at cell 0, empty terminator past the end
   assign cell_valid[WINDOW_MAX] = 1'b0;
   assign cell_value[WINDOW_MAX] = '0;
   assign cell_pos[WINDOW_MAX]   = '0;
   assign cell_keep[0]           = 1'b1;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      swe_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .POS_BITS    (POS_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .new_value (hold_sample_ff),
         .new_pos   (item_pos),
         .up_valid  (cell_valid[i+1]),
         .up_value  (cell_value[i+1]),
         .up_pos    (cell_pos[i+1]),
         .prev_keep (cell_keep[i]),
         .keep      (cell_keep[i+1]),
         .valid     (cell_valid[i]),
         .value     (cell_value[i]),
         .pos       (cell_pos[i])
      );
   end

   // the front cell holds the extreme until the next step, which waits for the transfer
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_BITS'(cell_value[0]);

endmodule

>>> rtl/core/swe_checker.sv
module swe_checker #(
   parameter int SAMPLE_BITS = swe_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [((SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata
);

   // a stalled result holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // reset empties the input holding register
   assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind sliding_window_extreme swe_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_swe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
